FILE: src/tmph_pkg.sv
// Shared widths, constants, register codes and types for the trimmed-mean pH converter.
package tmph_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int REF_W      = 13;
    localparam int FS_W       = 16;
    localparam int SLOPE_W    = 16;
    localparam int OFFSET_W   = 15;
    localparam int MV_W       = 16;
    localparam int PH_W       = 14;
    localparam int HELD_W     = 9;
    localparam int SUM_W      = 24;   // 256 samples of 16 bits
    localparam int DIV_NUM_W  = 37;   // sum times reference
    localparam int DIV_DEN_W  = 25;   // divisor times full scale
    localparam int PROD_W     = 33;   // slope times millivolts, signed
    localparam int PHQ_W      = 22;   // |product| / 1000
    localparam int PHM_W      = 60;   // |product| times the reciprocal of 1000
    localparam int PH_SUM_W   = 24;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int TRIM_MIN_COUNT = 5;
    localparam int TRIM_DROP      = 2;
    localparam int PH_SCALE       = 1000;
    localparam int PH_MAX         = 14000;

    // floor(x / 1000) = (x * PH_RECIP) >> PH_RECIP_SHIFT, exact for x below 2^32
    localparam int                      PH_RECIP_W     = 29;
    localparam int                      PH_RECIP_SHIFT = 38;
    localparam logic [PH_RECIP_W-1:0]   PH_RECIP       = 29'd274877907;

    localparam logic [REF_W-1:0]           RST_REFERENCE_MV   = 13'd3300;
    localparam logic [FS_W-1:0]            RST_ADC_FULL_SCALE = 16'd65535;
    localparam logic signed [SLOPE_W-1:0]  RST_SLOPE_MILLI    = 16'sd3500;
    localparam logic signed [OFFSET_W-1:0] RST_OFFSET_MILLI   = 15'sd0;

    typedef enum logic [1:0] {
        REG_REFERENCE_MV   = 2'd0,
        REG_ADC_FULL_SCALE = 2'd1,
        REG_SLOPE_MILLI    = 2'd2,
        REG_OFFSET_MILLI   = 2'd3
    } tmph_reg_t;

    typedef struct packed {
        logic [REF_W-1:0]           reference_mv;
        logic [FS_W-1:0]            adc_full_scale;
        logic signed [SLOPE_W-1:0]  slope_milli;
        logic signed [OFFSET_W-1:0] offset_milli;
    } tmph_cfg_t;

endpackage

FILE: src/tmph_ifs.sv
// Valid/ready channel interfaces for samples and results.
interface tmph_sample_if import tmph_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface tmph_result_if import tmph_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] average_code;
    logic [MV_W-1:0]     voltage_mv;
    logic [PH_W-1:0]     ph_milli;
    logic [HELD_W-1:0]   samples_held;

    modport source (output valid, output average_code, output voltage_mv,
                    output ph_milli, output samples_held, input ready);
    modport sink (input valid, input average_code, input voltage_mv,
                  input ph_milli, input samples_held, output ready);
endinterface

FILE: src/trimmed_mean_ph_converter.sv
// Top level: trimmed-mean filter over a sample ring RAM, scaled to millivolts and pH.
//
//   channel   dir   handshake          payload
//   adc       in    valid/ready        sample
//   reading   out   valid/ready        average_code, voltage_mv, ph_milli, samples_held
//   apb       in    psel/penable       paddr, pwdata -> prdata (pready tied high)
//
// Between accepting a beat and loading its result the block runs a walk over the ring RAM
// (one read per cycle, then a wait for the registered read data and the last fold), the
// trim and scale setup states, two passes of the shared 37-bit serial divider (average,
// millivolts), then the slope product, the reciprocal multiply by 1/1000 and the output.
// Reset clears control state, the slot pointer and the fill count; the RAM is not
// cleared, since the walk only visits slots already written.
// A new beat is taken only in idle; a finished result sits in the output register, so
// the next walk runs while it waits, and the block stalls before loading it only if the
// previous beat is still unread.
module trimmed_mean_ph_converter import tmph_pkg::*; #(
    parameter int SAMPLE_DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tmph_sample_if.sink           adc,
    tmph_result_if.source         reading,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = $clog2(SAMPLE_DEPTH);
    localparam int CW = $clog2(SAMPLE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT  = AW'(SAMPLE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(SAMPLE_DEPTH);
    localparam logic signed [PH_SUM_W-1:0] PH_HI = PH_SUM_W'(PH_MAX);

    // one-hot sequencer
    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_WALK   = 10'b00_0000_0010,
        ST_TRIM   = 10'b00_0000_0100,
        ST_SCALE  = 10'b00_0000_1000,
        ST_AVG    = 10'b00_0001_0000,
        ST_MV     = 10'b00_0010_0000,
        ST_PROD   = 10'b00_0100_0000,
        ST_PHGO   = 10'b00_1000_0000,
        ST_PHWAIT = 10'b01_0000_0000,
        ST_OUT    = 10'b10_0000_0000
    } tmph_state_t;

    tmph_cfg_t cfg;

    tmph_state_t                 state_reg, state_next;
    logic [AW-1:0]               slot_reg, slot_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               idx_reg, idx_next;
    logic                        rd_pend_reg, rd_pend_next;
    logic                        first_reg, first_next;
    logic [SUM_W-1:0]            sum_reg, sum_next;
    logic [SAMPLE_W-1:0]         min_reg, min_next;
    logic [SAMPLE_W-1:0]         max_reg, max_next;
    logic [SUM_W-1:0]            tsum_reg, tsum_next;
    logic [HELD_W-1:0]           tdiv_reg, tdiv_next;
    logic [DIV_NUM_W-1:0]        num_reg, num_next;
    logic [DIV_DEN_W-1:0]        den_reg, den_next;
    logic [SAMPLE_W-1:0]         avg_reg, avg_next;
    logic [MV_W-1:0]             mv_reg, mv_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic [PHM_W-1:0]            phm_reg, phm_next;
    logic [PHQ_W-1:0]            phq_reg, phq_next;
    logic                        out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]         out_avg_reg, out_avg_next;
    logic [MV_W-1:0]             out_mv_reg, out_mv_next;
    logic [PH_W-1:0]             out_ph_reg, out_ph_next;
    logic [HELD_W-1:0]           out_held_reg, out_held_next;

    logic                        accept;
    logic                        issue;
    logic [SAMPLE_W-1:0]         rd_data;
    logic                        trimmed;
    logic [FS_W-1:0]             fs_eff;
    logic [PROD_W-1:0]           prod_mag;
    logic signed [PH_SUM_W-1:0]  ph_s;
    logic                        out_free;

    logic                        div_start;
    logic [DIV_NUM_W-1:0]        div_dividend;
    logic [DIV_DEN_W-1:0]        div_divisor;
    logic                        div_busy;
    logic                        div_done;
    logic [DIV_NUM_W-1:0]        div_quo;

    tmph_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ring store: written on accept, walked from slot zero up to the fill count
    tmph_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (SAMPLE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (slot_reg),
        .wr_data (adc.sample),
        .rd_en   (issue),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    tmph_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign adc.ready = (state_reg == ST_IDLE);
    assign accept    = adc.valid && adc.ready;
    assign issue     = (state_reg == ST_WALK) && (idx_reg != count_reg);
    assign out_free  = !out_valid_reg || reading.ready;

    // fewer than five held samples: plain mean, else drop one min and one max
    assign trimmed  = HELD_W'(count_reg) >= HELD_W'(TRIM_MIN_COUNT);
    // zero full scale behaves as one
    assign fs_eff   = (cfg.adc_full_scale == '0) ? FS_W'(1) : cfg.adc_full_scale;
    assign prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);

    // pH: quotient of |slope*mV| by 1000, sign restored (truncation toward zero), plus the offset
    always_comb
    begin
        ph_s = $signed(PH_SUM_W'(phq_reg));
        if (prod_reg[PROD_W-1])
        begin
            ph_s = -ph_s;
        end
        ph_s = ph_s + PH_SUM_W'(cfg.offset_milli);
    end

    // divider operand select
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = num_reg;
        div_divisor  = den_reg;
        if (state_reg == ST_SCALE)
        begin
            div_start    = 1'b1;
            div_dividend = DIV_NUM_W'(tsum_reg);
            div_divisor  = DIV_DEN_W'(tdiv_reg);
        end
        else if (state_reg == ST_AVG)
        begin
            div_start = div_done;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        rd_pend_next   = issue;
        first_next     = first_reg;
        sum_next       = sum_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        tsum_next      = tsum_reg;
        tdiv_next      = tdiv_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        avg_next       = avg_reg;
        mv_next        = mv_reg;
        prod_next      = prod_reg;
        phm_next       = phm_reg;
        phq_next       = phq_reg;
        out_valid_next = out_valid_reg && !reading.ready;
        out_avg_next   = out_avg_reg;
        out_mv_next    = out_mv_reg;
        out_ph_next    = out_ph_reg;
        out_held_next  = out_held_reg;

        // fold in the word read last cycle
        if (rd_pend_reg)
        begin
            sum_next   = sum_reg + SUM_W'(rd_data);
            min_next   = (first_reg || rd_data < min_reg) ? rd_data : min_reg;
            max_next   = (first_reg || rd_data > max_reg) ? rd_data : max_reg;
            first_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    slot_next  = (slot_reg == LAST_SLOT) ? '0 : slot_reg + AW'(1);
                    count_next = (count_reg == FULL_COUNT) ? count_reg
                                                           : count_reg + CW'(1);
                    idx_next   = '0;
                    sum_next   = '0;
                    first_next = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (issue)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else if (!rd_pend_reg)
                begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                if (trimmed)
                begin
                    tsum_next = sum_reg - SUM_W'(min_reg) - SUM_W'(max_reg);
                    tdiv_next = HELD_W'(count_reg) - HELD_W'(TRIM_DROP);
                end
                else
                begin
                    tsum_next = sum_reg;
                    tdiv_next = HELD_W'(count_reg);
                end
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                // mV = S*ref / (D*fs): both products registered for the second pass
                num_next   = DIV_NUM_W'(tsum_reg) * DIV_NUM_W'(cfg.reference_mv);
                den_next   = DIV_DEN_W'(tdiv_reg) * DIV_DEN_W'(fs_eff);
                state_next = ST_AVG;
            end
            ST_AVG:
            begin
                if (div_done)
                begin
                    avg_next   = div_quo[SAMPLE_W-1:0];
                    state_next = ST_MV;
                end
            end
            ST_MV:
            begin
                if (div_done)
                begin
                    // saturate at full 16-bit range
                    mv_next    = (|div_quo[DIV_NUM_W-1:MV_W]) ? '1 : div_quo[MV_W-1:0];
                    state_next = ST_PROD;
                end
            end
            ST_PROD:
            begin
                prod_next  = PROD_W'(cfg.slope_milli)
                           * $signed(PROD_W'({1'b0, mv_reg}));
                state_next = ST_PHGO;
            end
            ST_PHGO:
            begin
                // |product| is below 2^31, so the reciprocal gives the exact quotient
                phm_next   = PHM_W'(prod_mag) * PHM_W'(PH_RECIP);
                state_next = ST_PHWAIT;
            end
            ST_PHWAIT:
            begin
                phq_next   = phm_reg[PH_RECIP_SHIFT +: PHQ_W];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_avg_next   = avg_reg;
                    out_mv_next    = mv_reg;
                    out_held_next  = HELD_W'(count_reg);
                    if (ph_s[PH_SUM_W-1])
                    begin
                        out_ph_next = '0;
                    end
                    else if (ph_s > PH_HI)
                    begin
                        out_ph_next = PH_W'(PH_MAX);
                    end
                    else
                    begin
                        out_ph_next = ph_s[PH_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rd_pend_reg   <= rd_pend_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        min_reg      <= min_next;
        max_reg      <= max_next;
        tsum_reg     <= tsum_next;
        tdiv_reg     <= tdiv_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        avg_reg      <= avg_next;
        mv_reg       <= mv_next;
        prod_reg     <= prod_next;
        phm_reg      <= phm_next;
        phq_reg      <= phq_next;
        out_avg_reg  <= out_avg_next;
        out_mv_reg   <= out_mv_next;
        out_ph_reg   <= out_ph_next;
        out_held_reg <= out_held_next;
    end

    assign reading.valid        = out_valid_reg;
    assign reading.average_code = out_avg_reg;
    assign reading.voltage_mv   = out_mv_reg;
    assign reading.ph_milli     = out_ph_reg;
    assign reading.samples_held = out_held_reg;

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("fill count beyond depth");

    a_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_WALK) && (count_reg != '0))
        else $error("accepted beat did not start a walk");

    a_ph_range: assert property (@(posedge clk) disable iff (!rst_n)
        reading.valid |-> (reading.ph_milli <= PH_W'(PH_MAX))
                          && (reading.samples_held != '0))
        else $error("result out of range");

endmodule

FILE: src/tmph_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tmph_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/tmph_div.sv
// Restoring divider, one quotient bit per cycle.
module tmph_div #(
    parameter int NUM_W = 37,
    parameter int DEN_W = 25
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   shifted;
    logic             ge;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        ge        = (shifted >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NUM_W);
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DEN_W'(shifted - {1'b0, den_reg}) : shifted[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: src/tmph_cfg.sv
// APB register file holding the calibration and scaling registers.
module tmph_cfg import tmph_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output tmph_cfg_t             cfg
);

    tmph_cfg_t cfg_reg, cfg_next;
    tmph_reg_t index;
    logic      wr;

    assign index  = tmph_reg_t'(paddr[3:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (index)
                REG_REFERENCE_MV:   cfg_next.reference_mv   = pwdata[REF_W-1:0];
                REG_ADC_FULL_SCALE: cfg_next.adc_full_scale = pwdata[FS_W-1:0];
                REG_SLOPE_MILLI:    cfg_next.slope_milli    = $signed(pwdata[SLOPE_W-1:0]);
                REG_OFFSET_MILLI:   cfg_next.offset_milli   = $signed(pwdata[OFFSET_W-1:0]);
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_REFERENCE_MV:   prdata = APB_DATA_W'(cfg_reg.reference_mv);
            REG_ADC_FULL_SCALE: prdata = APB_DATA_W'(cfg_reg.adc_full_scale);
            REG_SLOPE_MILLI:    prdata = APB_DATA_W'(unsigned'(cfg_reg.slope_milli));
            REG_OFFSET_MILLI:   prdata = APB_DATA_W'(unsigned'(cfg_reg.offset_milli));
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reference_mv   <= RST_REFERENCE_MV;
            cfg_reg.adc_full_scale <= RST_ADC_FULL_SCALE;
            cfg_reg.slope_milli    <= RST_SLOPE_MILLI;
            cfg_reg.offset_milli   <= RST_OFFSET_MILLI;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the trimmed-mean pH converter: random traffic, calibration sweeps.
module tb_top import tmph_pkg::*;;

    localparam int RING_DEPTH   = 16;
    // Room for the worst walk plus two divider passes, with margin.
    localparam int DRAIN_CYCLES = 300;
    // Longest quiet stretch in a correct run: one item, a long sender gap and the
    // longest receiver stall. Take it many times over.
    localparam int QUIET_LIMIT  = 20000;

    // One reading as it leaves the block.
    typedef struct packed {
        logic [SAMPLE_W-1:0] average_code;
        logic [MV_W-1:0]     voltage_mv;
        logic [PH_W-1:0]     ph_milli;
        logic [HELD_W-1:0]   samples_held;
    } reading_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tmph_sample_if adc_ch ();
    tmph_result_if rd_ch ();

    trimmed_mean_ph_converter #(
        .SAMPLE_DEPTH (RING_DEPTH)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .adc     (adc_ch),
        .reading (rd_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the block: ring of samples, write pointer, fill count and
    // the calibration registers as last written over APB.
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] ring [RING_DEPTH];
    int                  wr_slot;
    int                  fill;
    tmph_cfg_t           cfg_model;

    logic [SAMPLE_W-1:0] sample_q [$];    // codes waiting to be driven
    reading_t            reading_q [$];   // readings predicted, not yet seen
    int                  samples_queued;
    int                  samples_taken;
    int                  readings_seen;
    int                  settings_used;
    int                  fail_count;
    int                  quiet_cycles;
    bit                  sample_beat;     // adc beat at the last rising edge
    bit                  rx_steady;       // receiver always ready in this phase

    // Store one code, then work out the reading it causes: trimmed mean over
    // the held samples (one min and one max dropped once five or more are held),
    // scaled to mV with saturation, then to pH*1000 with clamping.
    function automatic reading_t filter_and_scale(input logic [SAMPLE_W-1:0] code);
        reading_t            r;
        longint unsigned     total;
        longint unsigned     divisor;
        longint unsigned     full;
        longint unsigned     mv;
        longint              ph;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        int                  i;
        ring[wr_slot] = code;
        wr_slot = (wr_slot == RING_DEPTH - 1) ? 0 : wr_slot + 1;
        if (fill < RING_DEPTH)
            fill++;
        lo = ring[0];
        hi = ring[0];
        total = 0;
        for (i = 0; i < fill; i++)
        begin
            total += ring[i];
            if (ring[i] < lo)
                lo = ring[i];
            if (ring[i] > hi)
                hi = ring[i];
        end
        if (fill < TRIM_MIN_COUNT)
        begin
            divisor = fill;
        end
        else
        begin
            total = total - lo - hi;
            divisor = fill - TRIM_DROP;
        end
        // zero full scale behaves as one
        full = (cfg_model.adc_full_scale == '0) ? 1 : cfg_model.adc_full_scale;
        mv = (total * cfg_model.reference_mv) / (divisor * full);
        if (mv > 65535)
            mv = 65535;
        // signed division truncates toward zero, as the block does
        ph = (longint'(cfg_model.slope_milli) * longint'(mv)) / PH_SCALE
             + longint'(cfg_model.offset_milli);
        if (ph < 0)
            ph = 0;
        if (ph > PH_MAX)
            ph = PH_MAX;
        r.average_code = SAMPLE_W'(total / divisor);
        r.voltage_mv   = MV_W'(mv);
        r.ph_milli     = PH_W'(ph);
        r.samples_held = HELD_W'(fill);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Rising edge: take adc beats into the shadow, check reading beats
    // against the oldest prediction, and watch for a hang.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        reading_t want;
        sample_beat <= adc_ch.valid && adc_ch.ready;
        if (rst_n)
        begin
            if ((adc_ch.valid && adc_ch.ready) || (rd_ch.valid && rd_ch.ready)
                || (psel && penable))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;

            // A reading is only loaded after the walk and both divider passes, so it never lands on
            // the edge that takes its own sample; pushing first is safe.
            if (adc_ch.valid && adc_ch.ready)
            begin
                reading_q.push_back(filter_and_scale(adc_ch.sample));
                samples_taken++;
            end

            if (rd_ch.valid && rd_ch.ready)
            begin
                readings_seen++;
                if (reading_q.size() == 0)
                begin
                    $error("reading beat with nothing outstanding: avg %0d mv %0d ph %0d held %0d",
                           rd_ch.average_code, rd_ch.voltage_mv, rd_ch.ph_milli,
                           rd_ch.samples_held);
                    fail_count++;
                end
                else
                begin
                    want = reading_q.pop_front();
                    if (rd_ch.average_code !== want.average_code)
                    begin
                        $error("average_code: expected %0d, got %0d",
                               want.average_code, rd_ch.average_code);
                        fail_count++;
                    end
                    if (rd_ch.voltage_mv !== want.voltage_mv)
                    begin
                        $error("voltage_mv: expected %0d, got %0d",
                               want.voltage_mv, rd_ch.voltage_mv);
                        fail_count++;
                    end
                    if (rd_ch.ph_milli !== want.ph_milli)
                    begin
                        $error("ph_milli: expected %0d, got %0d",
                               want.ph_milli, rd_ch.ph_milli);
                        fail_count++;
                    end
                    if (rd_ch.samples_held !== want.samples_held)
                    begin
                        $error("samples_held: expected %0d, got %0d",
                               want.samples_held, rd_ch.samples_held);
                        fail_count++;
                    end
                end
            end

            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles, %0d readings outstanding",
                         quiet_cycles, reading_q.size());
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sample driver: bursts of random length, gaps of random length
    // (zero, short, or long enough to straddle a whole computation).
    // A beat on the bus is held until the block takes it.
    // ------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            adc_ch.valid <= 1'b0;
        end
        else if (adc_ch.valid && !sample_beat)
        begin
            // still waiting on ready: hold the beat
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            adc_ch.valid <= 1'b0;
        end
        else if (sample_q.size() == 0)
        begin
            adc_ch.valid <= 1'b0;
        end
        else
        begin
            adc_ch.valid  <= 1'b1;
            adc_ch.sample <= sample_q.pop_front();
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 20);
                case ($urandom_range(0, 2))
                    0: gap_left = 0;
                    1: gap_left = $urandom_range(1, 8);
                    default: gap_left = $urandom_range(1, 300);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Reading sink: runs of ready high and low, with the odd long stall.
    // Some phases keep ready high throughout.
    // ------------------------------------------------------------------
    int rx_run;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rd_ch.ready <= 1'b0;
        end
        else if (rx_steady)
        begin
            rd_ch.ready <= 1'b1;
        end
        else if (rx_run == 0)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                rd_ch.ready <= 1'b1;
                rx_run = $urandom_range(1, 40);
            end
            else
            begin
                rd_ch.ready <= 1'b0;
                rx_run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 400)
                                                     : $urandom_range(1, 20);
            end
        end
        else
        begin
            rx_run--;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------

    // Write one register over APB: setup cycle, then access cycle.
    task automatic apb_write(input tmph_reg_t idx, input logic [APB_DATA_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_REFERENCE_MV:   cfg_model.reference_mv   = val[REF_W-1:0];
            REG_ADC_FULL_SCALE: cfg_model.adc_full_scale = val[FS_W-1:0];
            REG_SLOPE_MILLI:    cfg_model.slope_milli    = val[SLOPE_W-1:0];
            REG_OFFSET_MILLI:   cfg_model.offset_milli   = val[OFFSET_W-1:0];
            default: ;
        endcase
    endtask

    // Block until every queued code is taken and every reading is back.
    task automatic wait_for_readings();
        while (samples_taken != samples_queued || reading_q.size() != 0)
            @(posedge clk);
    endtask

    // New calibration, only once the block has gone idle.
    task automatic calibrate(input logic [REF_W-1:0] ref_mv, input logic [FS_W-1:0] fs,
                             input logic signed [SLOPE_W-1:0] slope,
                             input logic signed [OFFSET_W-1:0] offset);
        wait_for_readings();
        repeat (DRAIN_CYCLES) @(posedge clk);
        apb_write(REG_REFERENCE_MV, {{(APB_DATA_W-REF_W){1'b0}}, ref_mv});
        apb_write(REG_ADC_FULL_SCALE, {{(APB_DATA_W-FS_W){1'b0}}, fs});
        apb_write(REG_SLOPE_MILLI, {{(APB_DATA_W-SLOPE_W){slope[SLOPE_W-1]}}, slope});
        apb_write(REG_OFFSET_MILLI, {{(APB_DATA_W-OFFSET_W){offset[OFFSET_W-1]}}, offset});
        rx_steady = ($urandom_range(0, 3) == 0);
        settings_used++;
    endtask

    task automatic push_code(input logic [SAMPLE_W-1:0] code);
        sample_q.push_back(code);
        samples_queued++;
    endtask

    // Random codes in a mix of shapes: full range, a tight cluster with the
    // odd rail spike (what trimming is for), repeats that tie min or max, and
    // small codes.
    task automatic push_random(input int n, input bit pause_midway);
        int                  k;
        int                  base;
        logic [SAMPLE_W-1:0] prev;
        base = $urandom_range(0, 65535 - 64);
        prev = SAMPLE_W'($urandom_range(0, 65535));
        for (k = 0; k < n; k++)
        begin
            if (pause_midway && k == n / 2)
                wait_for_readings();   // sender holds off until the pipe is empty
            case ($urandom_range(0, 5))
                0, 1:    prev = SAMPLE_W'($urandom_range(0, 65535));
                2:       prev = SAMPLE_W'(base + $urandom_range(0, 64));
                3:       prev = $urandom_range(0, 1) ? '1 : '0;
                4:       ;   // repeat the last code
                default: prev = SAMPLE_W'($urandom_range(0, 255));
            endcase
            push_code(prev);
        end
    endtask

    initial
    begin
        int                         ph_idx;
        logic [REF_W-1:0]           r_ref;
        logic [FS_W-1:0]            r_fs;
        logic signed [SLOPE_W-1:0]  r_slope;
        logic signed [OFFSET_W-1:0] r_off;

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        adc_ch.valid  = 1'b0;
        adc_ch.sample = '0;
        rd_ch.ready   = 1'b0;
        rx_steady     = 1'b0;
        burst_left    = 0;
        gap_left      = 0;
        rx_run        = 0;
        wr_slot       = 0;
        fill          = 0;
        cfg_model.reference_mv   = RST_REFERENCE_MV;
        cfg_model.adc_full_scale = RST_ADC_FULL_SCALE;
        cfg_model.slope_milli    = RST_SLOPE_MILLI;
        cfg_model.offset_milli   = RST_OFFSET_MILLI;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, on reset calibration: plain mean while under five held,
        // first trimmed average at five, rails, alternating bit patterns,
        // ties at min and max, then wrap of the ring past sixteen.
        push_code(16'd0);
        push_code(16'hFFFF);
        push_code(16'd1);
        push_code(16'hFFFE);
        push_code(16'h8000);
        push_code(16'h5555);
        push_code(16'hAAAA);
        push_code(16'd0);
        push_code(16'd0);
        push_code(16'hFFFF);
        push_code(16'hFFFF);
        push_code(16'd12345);
        push_code(16'd7);
        push_code(16'hFFFF);
        push_code(16'h7FFF);
        push_code(16'd1);
        push_code(16'd300);
        push_code(16'd301);
        push_code(16'd302);
        push_code(16'hFFFF);
        push_code(16'd0);
        push_code(16'h00FF);

        // Zero reference: every voltage is 0 mV, pH is the offset.
        calibrate('0, '1, 16'sd3500, 15'sd0);
        push_random(60, 1'b0);
        // Zero full scale with the largest reference: voltage saturates, pH clamps high.
        calibrate('1, '0, 16'sh7FFF, 15'sh3FFF);
        push_random(60, 1'b1);
        // Full scale of one, most negative slope and offset: pH clamps at zero.
        calibrate(13'd5000, 16'd1, 16'sh8000, 15'sh4000);
        push_random(60, 1'b0);
        // Smallest useful reference, spec-limit slope and offset.
        calibrate(13'd1, 16'hFFFF, -16'sd20000, 15'sd14000);
        push_random(60, 1'b0);

        for (ph_idx = 0; ph_idx < 10; ph_idx++)
        begin
            r_ref   = REF_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                         : $urandom_range(1, 5000));
            case ($urandom_range(0, 7))
                0:       r_fs = '0;
                1, 2:    r_fs = FS_W'($urandom_range(1, 4095));
                default: r_fs = FS_W'($urandom_range(4096, 65535));
            endcase
            r_slope = SLOPE_W'(($urandom_range(0, 3) == 0)
                               ? $urandom_range(0, 65535)
                               : $urandom_range(0, 40000) - 20000);
            r_off   = OFFSET_W'(($urandom_range(0, 3) == 0)
                                ? $urandom_range(0, 32767)
                                : $urandom_range(0, 28000) - 14000);
            calibrate(r_ref, r_fs, r_slope, r_off);
            push_random(105, ph_idx % 3 == 0);
        end

        wait_for_readings();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d samples across %0d calibrations plus reset values; %0d readings checked.",
                 samples_taken, settings_used, readings_seen);
        $display("Fill from empty, ring wrap, zero reference and full scale, saturation and both pH clamps hit.");
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
